// ----- design/htfl_pkg.sv -----
// shared constants and types for the handle table with intrusive free list
`timescale 1ns / 1ps

package htfl_pkg;

    localparam int DEPTH        = 1024;
    localparam int PAYLOAD_BITS = 48;
    localparam int FIRST_INDEX  = 1;

    localparam int IDX_W     = $clog2(DEPTH);
    localparam int HW_W      = $clog2(DEPTH + 1);
    localparam int LINK_W    = IDX_W + 1;
    localparam int DATA_W    = (PAYLOAD_BITS > LINK_W) ? PAYLOAD_BITS : LINK_W;
    localparam int ENTRY_W   = DATA_W + 1;
    localparam int HANDLE_W  = 32;
    localparam int PORT_PL_W = 48;

    typedef logic [1:0]          kind_t;
    typedef logic [1:0]          status_t;
    typedef logic [ENTRY_W-1:0]  entry_t;
    typedef logic [IDX_W-1:0]    slot_t;
    typedef logic [HW_W-1:0]     hw_t;
    typedef logic [HANDLE_W-1:0] handle_t;

    localparam kind_t KIND_ALLOC  = 2'd0;
    localparam kind_t KIND_LOOKUP = 2'd1;
    localparam kind_t KIND_DROP   = 2'd2;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_INVALID = 2'd1;
    localparam status_t ST_FULL    = 2'd2;

endpackage

// ----- design/htfl_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module htfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/handle_table_free_list.sv -----
// top level of the resource handle table with a free list kept in the free slots
`timescale 1ns / 1ps

// channel  | direction | handshake            | fields
// ---------+-----------+----------------------+-------------------------------
// req      | in        | req_valid/req_stall  | kind, handle_in, payload_in
// rsp      | out       | rsp_valid/rsp_stall  | status, handle_out, payload_out
//
// each word is read from the slot ram in S_IDLE, then checked, written back and loaded
// into the response register in S_EXEC; no new word is taken until S_EXEC ends
// the response register lets the next request in while a response still waits
// reset clears the free-list head, its nonempty flag and the high-water mark;
// the slot ram needs no clearing since only slots below the mark are ever used
// a stalled response holds S_EXEC until the response register frees

module handle_table_free_list (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  htfl_pkg::kind_t          kind,
    input  htfl_pkg::handle_t        handle_in,
    input  logic [47:0]              payload_in,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output htfl_pkg::status_t        status,
    output htfl_pkg::handle_t        handle_out,
    output logic [47:0]              payload_out
);

    import htfl_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // control state
    logic    state_reg, state_next;
    slot_t   free_head_reg, free_head_next;
    logic    nonempty_reg, nonempty_next;
    hw_t     hw_reg, hw_next;
    logic    out_valid_reg, out_valid_next;

    // captured request word
    kind_t                   kind_reg;
    handle_t                 handle_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic                    in_range_reg;
    slot_t                   slot_reg;

    // response register
    status_t               status_reg, status_next;
    handle_t               hout_reg, hout_next;
    logic [PORT_PL_W-1:0]  pout_reg, pout_next;

    // ram ports
    logic   ram_we;
    slot_t  ram_waddr;
    entry_t ram_wdata;
    logic   ram_re;
    slot_t  ram_raddr;
    entry_t ram_rdata;

    logic    accept;
    logic    finish;
    handle_t idx_full;
    logic    in_range;
    logic    live;
    slot_t   alloc_slot;

    htfl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    // response register is free or is being emptied this cycle
    assign finish    = (state_reg == S_EXEC) && (!out_valid_reg || !rsp_stall);

    // handle range check against base and high-water mark
    assign idx_full = handle_in - HANDLE_W'(FIRST_INDEX);
    assign in_range = (handle_in >= HANDLE_W'(FIRST_INDEX)) &&
                      (idx_full < HANDLE_W'(hw_reg));

    // read the free-list head for allocate, the named slot otherwise
    assign ram_re    = accept;
    assign ram_raddr = (kind == KIND_ALLOC) ? free_head_reg : idx_full[IDX_W-1:0];

    // live slot: in range and no free mark in the stored entry
    assign live = in_range_reg && !ram_rdata[ENTRY_W-1];

    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        nonempty_next  = nonempty_reg;
        hw_next        = hw_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        hout_next      = hout_reg;
        pout_next      = pout_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = {1'b0, DATA_W'(payload_reg)};
        alloc_slot     = free_head_reg;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_INVALID;
                    hout_next      = handle_reg;
                    pout_next      = '0;
                    case (kind_reg) inside
                        KIND_ALLOC:
                        begin
                            if (nonempty_reg)
                            begin
                                // pop the free-list head, its link is in the entry
                                alloc_slot     = free_head_reg;
                                free_head_next = ram_rdata[IDX_W-1:0];
                                nonempty_next  = ram_rdata[IDX_W];
                                ram_we         = 1'b1;
                                status_next    = ST_OK;
                            end
                            else if (hw_reg < HW_W'(DEPTH))
                            begin
                                // take the next never-used slot
                                alloc_slot  = hw_reg[IDX_W-1:0];
                                hw_next     = HW_W'(hw_reg + 1'b1);
                                ram_we      = 1'b1;
                                status_next = ST_OK;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                            ram_waddr = alloc_slot;
                            if (ram_we)
                            begin
                                hout_next = HANDLE_W'(alloc_slot) + HANDLE_W'(FIRST_INDEX);
                            end
                        end
                        KIND_LOOKUP, KIND_DROP:
                        begin
                            if (live)
                            begin
                                status_next = ST_OK;
                                pout_next   = PORT_PL_W'(ram_rdata[PAYLOAD_BITS-1:0]);
                                if (kind_reg == KIND_DROP)
                                begin
                                    // push the slot, linking to the old head
                                    ram_we         = 1'b1;
                                    ram_wdata      = {1'b1,
                                                      DATA_W'({nonempty_reg, free_head_reg})};
                                    free_head_next = slot_reg;
                                    nonempty_next  = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            nonempty_reg  <= 1'b0;
            hw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            nonempty_reg  <= nonempty_next;
            hw_reg        <= hw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= kind;
            handle_reg   <= handle_in;
            payload_reg  <= PAYLOAD_BITS'(payload_in);
            in_range_reg <= in_range;
            slot_reg     <= idx_full[IDX_W-1:0];
        end
        status_reg <= status_next;
        hout_reg   <= hout_next;
        pout_reg   <= pout_next;
    end

    assign rsp_valid   = out_valid_reg;
    assign status      = status_reg;
    assign handle_out  = hout_reg;
    assign payload_out = pout_reg;

endmodule

// ----- test/tb_handle_table_free_list.sv -----
// self-checking testbench for the handle table with an intrusive free list
`timescale 1ns / 1ps

import htfl_pkg::*;

// the fourth kind code has no operation behind it
localparam kind_t KIND_UNUSED = 2'd3;
localparam logic [47:0] PAYLOAD_MASK = 48'((64'd1 << PAYLOAD_BITS) - 64'd1);

// one slot of the shadow table: a free slot carries a link, a live one a payload
typedef struct {
    bit          free_mark;
    bit          next_valid;
    slot_t       link;
    logic [47:0] payload;
} slot_entry_t;

typedef struct {
    status_t     status;
    handle_t     handle;
    logic [47:0] payload;
} reply_t;

// shadow copy of the handle table plus the replies it still owes
class handle_table_shadow;
    slot_entry_t slots [DEPTH];
    slot_t       free_head;
    bit          free_nonempty;
    int unsigned high_water;
    handle_t     live_handles [$];
    reply_t      pending_replies [$];
    int          errors;

    function new();
        free_head     = '0;
        free_nonempty = 1'b0;
        high_water    = 0;
        errors        = 0;
    endfunction

    // apply one accepted request word and queue the reply it must produce
    function void apply_request(kind_t k, handle_t h, logic [47:0] p);
        reply_t          r;
        slot_t           slot;
        longint unsigned idx;
        bit              live;
        r.status  = ST_INVALID;
        r.handle  = h;
        r.payload = '0;
        p = p & PAYLOAD_MASK;
        case (k)
            KIND_ALLOC:
            begin
                if (free_nonempty || high_water < DEPTH)
                begin
                    if (free_nonempty)
                    begin
                        slot          = free_head;
                        free_head     = slots[slot].link;
                        free_nonempty = slots[slot].next_valid;
                    end
                    else
                    begin
                        slot       = slot_t'(high_water);
                        high_water = high_water + 1;
                    end
                    slots[slot]  = '{1'b0, 1'b0, '0, p};
                    r.status     = ST_OK;
                    r.handle     = handle_t'(slot) + handle_t'(FIRST_INDEX);
                    live_handles = {live_handles, r.handle};
                end
                else
                    r.status = ST_FULL;
            end
            KIND_LOOKUP, KIND_DROP:
            begin
                live = 1'b0;
                idx  = 0;
                if (h >= handle_t'(FIRST_INDEX))
                begin
                    idx = longint'(h - handle_t'(FIRST_INDEX));
                    if (idx < high_water && !slots[idx].free_mark)
                        live = 1'b1;
                end
                if (live)
                begin
                    slot      = slot_t'(idx);
                    r.status  = ST_OK;
                    r.payload = slots[slot].payload & PAYLOAD_MASK;
                    if (k == KIND_DROP)
                    begin
                        slots[slot]   = '{1'b1, free_nonempty, free_head, '0};
                        free_head     = slot;
                        free_nonempty = 1'b1;
                        for (int i = 0; i < live_handles.size(); i++)
                        begin
                            if (live_handles[i] == h)
                            begin
                                live_handles.delete(i);
                                break;
                            end
                        end
                    end
                end
            end
            default:
            begin
                // unused kind: invalid, state untouched
            end
        endcase
        pending_replies = {pending_replies, r};
    endfunction

    function void check_response(status_t s, handle_t h, logic [47:0] p);
        reply_t e;
        if (pending_replies.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected response, expected none, actual status %0d handle %h payload %h",
                     $time, s, h, p);
            return;
        end
        e = pending_replies.pop_front();
        if (s !== e.status)
        begin
            errors++;
            $display("%0t: status mismatch, expected %0d actual %0d", $time, e.status, s);
        end
        if (h !== e.handle)
        begin
            errors++;
            $display("%0t: handle_out mismatch, expected %h actual %h", $time, e.handle, h);
        end
        if (p !== e.payload)
        begin
            errors++;
            $display("%0t: payload_out mismatch, expected %h actual %h", $time, e.payload, p);
        end
    endfunction
endclass

module tb_handle_table_free_list;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request channel, all driven from time zero
    logic        req_valid  = 1'b0;
    logic        req_stall;
    kind_t       kind       = KIND_ALLOC;
    handle_t     handle_in  = '0;
    logic [47:0] payload_in = '0;

    // response channel
    logic        rsp_valid;
    logic        rsp_stall  = 1'b0;
    status_t     status;
    handle_t     handle_out;
    logic [47:0] payload_out;

    handle_table_shadow shadow;

    // sender pacing: words go out in bursts separated by idle gaps
    int burst_left = 0;

    // receiver stall pattern state
    int stall_mode      = 0;
    int stall_mode_left = 0;
    int stall_run_left  = 0;
    bit stall_on        = 1'b0;

    handle_table_free_list dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .kind        (kind),
        .handle_in   (handle_in),
        .payload_in  (payload_in),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .handle_out  (handle_out),
        .payload_out (payload_out)
    );

    always #10 clk = ~clk;

    // receiver: switches between no stall, scattered stalls and long stall runs
    always @(negedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(50, 300);
        end
        else
            stall_mode_left--;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (stall_run_left > 0)
                    stall_run_left--;
                else
                begin
                    stall_on       = !stall_on;
                    stall_run_left = stall_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                rsp_stall <= stall_on;
            end
        endcase
    end

    // response monitor: a word is taken when valid is high and stall low at the edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            shadow.check_response(status, handle_out, payload_out);
    end

    function automatic logic [47:0] rand_payload();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[47:0];
    endfunction

    // drive one request word and hold it until the block takes it
    task automatic send_word(kind_t k, handle_t h, logic [47:0] p);
        int gap;
        if (burst_left == 0)
        begin
            // a quarter of the bursts follow straight on with no gap
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        req_valid  <= 1'b1;
        kind       <= k;
        handle_in  <= h;
        payload_in <= p;
        do
            @(posedge clk);
        while (req_stall);
        // the prediction is made at acceptance so the next pick sees current state
        shadow.apply_request(k, h, p);
    endtask

    // hold off the sender until every owed reply has come back
    task automatic wait_replies();
        @(negedge clk);
        req_valid <= 1'b0;
        while (shadow.pending_replies.size() > 0)
            @(negedge clk);
    endtask

    // one random word; the percentages bias allocation against dropping
    task automatic random_word(int alloc_pct, int drop_pct);
        int      r;
        int      noise;
        kind_t   k;
        handle_t h;
        r = $urandom_range(0, 99);
        if (r < alloc_pct || (r < 88 && shadow.live_handles.size() == 0))
            send_word(KIND_ALLOC, handle_t'($urandom), rand_payload());
        else if (r < 88)
        begin
            // well-formed access on a handle that is live right now
            h = shadow.live_handles[$urandom_range(0, shadow.live_handles.size() - 1)];
            k = (r < alloc_pct + drop_pct) ? KIND_DROP : KIND_LOOKUP;
            send_word(k, h, rand_payload());
        end
        else
        begin
            noise = $urandom_range(0, 4);
            k     = ($urandom_range(0, 1) == 0) ? KIND_LOOKUP : KIND_DROP;
            case (noise)
                0:  h = (FIRST_INDEX > 0) ? handle_t'($urandom_range(0, FIRST_INDEX - 1)) : '0;
                1:  h = (shadow.high_water > 0)
                        ? handle_t'(FIRST_INDEX + $urandom_range(0, shadow.high_water - 1))
                        : '0;
                2:  h = handle_t'(FIRST_INDEX + shadow.high_water + $urandom_range(0, 3));
                default: h = handle_t'($urandom);
            endcase
            if (noise == 4)
                k = KIND_UNUSED;
            send_word(k, h, rand_payload());
        end
    endtask

    // timeout guard
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        shadow = new();

        // reset held low from time zero, released on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, field extremes, unused kind
        send_word(KIND_LOOKUP, handle_t'(0), '0);
        send_word(KIND_DROP, handle_t'(FIRST_INDEX), '1);
        send_word(KIND_LOOKUP, '1, '0);
        send_word(KIND_UNUSED, '1, '1);
        // three fresh slots from the high-water mark
        send_word(KIND_ALLOC, '1, '0);
        send_word(KIND_ALLOC, '0, '1);
        send_word(KIND_ALLOC, 32'h5555_5555, 48'haaaa_5555_aaaa);
        send_word(KIND_LOOKUP, handle_t'(FIRST_INDEX), '0);
        send_word(KIND_LOOKUP, handle_t'(FIRST_INDEX + 1), '0);
        // just past the high-water mark
        send_word(KIND_LOOKUP, handle_t'(FIRST_INDEX + 3), '0);
        // drop, then touch the freed slot twice
        send_word(KIND_DROP, handle_t'(FIRST_INDEX + 1), '0);
        send_word(KIND_LOOKUP, handle_t'(FIRST_INDEX + 1), '0);
        send_word(KIND_DROP, handle_t'(FIRST_INDEX + 1), '0);
        // second drop links onto the first freed slot
        send_word(KIND_DROP, handle_t'(FIRST_INDEX), '1);
        // reuse pops the free list in order, then the mark grows again
        send_word(KIND_ALLOC, '0, 48'h0000_0000_0001);
        send_word(KIND_ALLOC, '0, 48'h8000_0000_0000);
        send_word(KIND_ALLOC, '1, 48'h1234_5678_9abc);
        // unused kind on a live handle leaves it alone
        send_word(KIND_UNUSED, handle_t'(FIRST_INDEX), '1);
        send_word(KIND_LOOKUP, handle_t'(FIRST_INDEX), '0);
        send_word(KIND_DROP, handle_t'(FIRST_INDEX + 3), '0);
        send_word(KIND_DROP, handle_t'(FIRST_INDEX + 2), '0);
        send_word(KIND_LOOKUP, handle_t'(0), '1);
        wait_replies();

        // balanced mix
        repeat (400) random_word(45, 20);

        // fill the table until nothing is left, then push against the full table
        while (shadow.free_nonempty || shadow.high_water < DEPTH)
        begin
            if ($urandom_range(0, 99) < 85)
                send_word(KIND_ALLOC, handle_t'($urandom), rand_payload());
            else
                random_word(40, 10);
        end
        repeat (20) random_word(50, 0);
        wait_replies();

        // drop heavy: builds a long free list inside the table
        repeat (500) random_word(15, 50);

        // mix again over the scattered free list
        repeat (200) random_word(40, 25);

        // drain and let any stray response show up
        wait_replies();
        repeat (10) @(posedge clk);

        if (shadow.errors == 0 && shadow.pending_replies.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
